// ===== sv/gf2l_pkg.sv =====
// Package for the GF(2^113) ladder block: field constants, payload types, opcodes.
// No dependencies.
`timescale 1ns / 1ps
package gf2l_pkg;
    localparam int FIELD_BITS_C = 113;
    localparam int WORD_BITS_C  = 64;
    localparam logic [112:0] CURVE_B =
        113'h0E8BEE4D3E2260744188BE0E9C723;
    localparam logic [112:0] BASE_X =
        113'h09D73616F35F4AB1407D73562C10F;
    localparam logic [112:0] POLY_LOW = 113'h201;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_INIT = 2'd1,
        OP_STEP = 2'd2,
        OP_READ = 2'd3
    } opcode_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  target;
        logic        word_index;
        logic [63:0] load_word;
        logic        key_bit;
    } req_t;

    typedef struct packed {
        logic [63:0] read_word;
        logic        mismatch;
        logic [7:0]  error_total;
    } rsp_t;
endpackage

// ===== sv/gf2m_ladder_step_with_fault_check.sv =====
// Top level of the GF(2^113) Lopez-Dahab ladder with redundancy check.
// Depends on gf2l_pkg.
`timescale 1ns / 1ps
// Usage:
//   in_valid/in_ready carry one request (req_t): load seed word, init,
//   key-bit step, or read coordinate word. out_valid/out_ready carry one
//   response (rsp_t) per request.
//   All field multiplications run on one shared bit-serial multiplier that
//   handles one bit of the multiplier operand per cycle, after an
//   operand-load step; adds and copies write the register file directly. A
//   microcode sequencer walks a list of multiply, add and copy steps over
//   a small register file.
//   Load and read go straight from idle to the response; init runs 20
//   products and 4 adds; the first step after init runs 11 products and
//   5 adds/copies; later steps, with the shadow update and the check,
//   run 29 products and 10 adds/copies.
//   One request is worked at a time; in_ready is low while busy or
//   while a response waits, so a new request is taken at the earliest
//   in the cycle after the response is accepted.
//   Reset clears all coordinate and seed state, the shadow flag and the
//   error count. If the receiver stalls, the response is held in the
//   output register and no new request is taken.
module gf2m_ladder_step_with_fault_check
    import gf2l_pkg::*;
#(
    parameter int FIELD_BITS = FIELD_BITS_C,
    parameter int WORD_BITS  = WORD_BITS_C
)(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output rsp_t out_data
);
    localparam int HI_BITS = FIELD_BITS - WORD_BITS;
    typedef logic [FIELD_BITS-1:0] fe_t;

    // register file: 0 p1x 1 p1z 2 p2x 3 p2z 4 pvx 5 pvz 6 gz 7 rs
    // 8..15 temporaries
    typedef enum logic [1:0] { U_MUL, U_ADD, U_CPY } uop_kind_t;
    typedef struct packed {
        uop_kind_t  kind;
        logic [4:0] a;   // 16 = BASE_X, 17 = CURVE_B
        logic [4:0] b;
        logic [3:0] d;
    } uop_t;

    localparam logic [4:0] RB = 5'd16;
    localparam logic [4:0] RC = 5'd17;

    typedef enum logic [2:0] { S_IDLE, S_RUN, S_MUL, S_RESP } state_t;

    state_t       state_reg;
    fe_t          rf_reg [16];
    logic         started_reg;
    logic [7:0]   fail_reg;
    rsp_t         rsp_reg;
    req_t         req_reg;
    logic [5:0]   pc_reg;
    logic [6:0]   bit_reg;
    fe_t          acc_reg, ma_reg, mb_reg;

    function automatic uop_t mk(uop_kind_t k, logic [4:0] a, logic [4:0] b, logic [3:0] d);
        uop_t u;
        u.kind = k; u.a = a; u.b = b; u.d = d;
        return u;
    endfunction

    // Programs. pt_add(x1,z1,x2,z2): f=x1*z2 g=x2*z1 z=(f+g)^2 x=B*z+f*g
    // Init: t8=B*gz, p1=(t8,gz); dbl -> (t10,t11); bx=rs*t10 bz=rs*t11
    function automatic uop_t prog(logic [1:0] sel, logic [5:0] pc, logic kb);
        uop_t u;
        logic [4:0] ax, az, bx, bz;
        u = mk(U_CPY, 5'd0, 5'd0, 4'd0);
        if (sel == 2'd0) begin
            case (pc)
                0: u = mk(U_MUL, RB, 5'd6, 4'd8);
                1: u = mk(U_MUL, 5'd8, 5'd8, 4'd9);   // a=x^2
                2: u = mk(U_MUL, 5'd6, 5'd6, 4'd10);  // b=z^2
                3: u = mk(U_MUL, 5'd9, 5'd10, 4'd11); // z2
                4: u = mk(U_MUL, 5'd9, 5'd9, 4'd12);
                5: u = mk(U_MUL, 5'd10, 5'd10, 4'd13);
                6: u = mk(U_MUL, RC, 5'd13, 4'd13);
                7: u = mk(U_ADD, 5'd12, 5'd13, 4'd10); // x2
                8: u = mk(U_MUL, 5'd7, 5'd10, 4'd14); // bx
                9: u = mk(U_MUL, 5'd7, 5'd11, 4'd15); // bz
                // add (bx,bz)+(p1) -> p1
                10: u = mk(U_MUL, 5'd14, 5'd6, 4'd9);  // f
                11: u = mk(U_MUL, 5'd8, 5'd15, 4'd10); // g
                12: u = mk(U_ADD, 5'd9, 5'd10, 4'd12);
                13: u = mk(U_MUL, 5'd12, 5'd12, 4'd1);
                14: u = mk(U_MUL, 5'd9, 5'd10, 4'd12);
                15: u = mk(U_MUL, RB, 5'd1, 4'd13);
                16: u = mk(U_ADD, 5'd12, 5'd13, 4'd0);
                // dbl (bx,bz) -> p2
                17: u = mk(U_MUL, 5'd14, 5'd14, 4'd9);
                18: u = mk(U_MUL, 5'd15, 5'd15, 4'd10);
                19: u = mk(U_MUL, 5'd9, 5'd10, 4'd3);
                20: u = mk(U_MUL, 5'd9, 5'd9, 4'd12);
                21: u = mk(U_MUL, 5'd10, 5'd10, 4'd13);
                22: u = mk(U_MUL, RC, 5'd13, 4'd13);
                23: u = mk(U_ADD, 5'd12, 5'd13, 4'd2);
                default: u = mk(U_CPY, 5'd0, 5'd0, 4'd0);
            endcase
        end else begin
            // step: the key bit picks which of p1/p2 is the doubled point
            ax = kb ? 5'd2 : 5'd0;  az = kb ? 5'd3 : 5'd1; // doubled point
            bx = kb ? 5'd0 : 5'd2;  bz = kb ? 5'd1 : 5'd3; // other
            case (pc)
                // shadow: started -> pv = add(pv, doubled-side) in order
                0: u = mk(U_MUL, kb ? 5'd4 : 5'd0, kb ? 5'd3 : 5'd5, 4'd8);
                1: u = mk(U_MUL, kb ? 5'd2 : 5'd4, kb ? 5'd5 : 5'd1, 4'd9);
                2: u = mk(U_ADD, 5'd8, 5'd9, 4'd10);
                3: u = mk(U_MUL, 5'd10, 5'd10, 4'd5);
                4: u = mk(U_MUL, 5'd8, 5'd9, 4'd10);
                5: u = mk(U_MUL, RB, 5'd5, 4'd11);
                6: u = mk(U_ADD, 5'd10, 5'd11, 4'd4);
                // ladder add p1+p2 -> other side (t12,t13)
                7: u = mk(U_MUL, 5'd0, 5'd3, 4'd8);
                8: u = mk(U_MUL, 5'd2, 5'd1, 4'd9);
                9: u = mk(U_ADD, 5'd8, 5'd9, 4'd10);
                10: u = mk(U_MUL, 5'd10, 5'd10, 4'd13);
                11: u = mk(U_MUL, 5'd8, 5'd9, 4'd10);
                12: u = mk(U_MUL, RB, 5'd13, 4'd11);
                13: u = mk(U_ADD, 5'd10, 5'd11, 4'd12);
                // dbl of doubled side in place
                14: u = mk(U_MUL, ax, ax, 4'd8);
                15: u = mk(U_MUL, az, az, 4'd9);
                16: u = mk(U_MUL, 5'd8, 5'd9, az[3:0]);
                17: u = mk(U_MUL, 5'd8, 5'd8, 4'd10);
                18: u = mk(U_MUL, 5'd9, 5'd9, 4'd11);
                19: u = mk(U_MUL, RC, 5'd11, 4'd11);
                20: u = mk(U_ADD, 5'd10, 5'd11, ax[3:0]);
                21: u = mk(U_CPY, 5'd12, 5'd0, bx[3:0]);
                22: u = mk(U_CPY, 5'd13, 5'd0, bz[3:0]);
                // check: l = add(pv,p2) -> (t14,t15), r = dbl(p1) -> (t12,t13)
                23: u = mk(U_MUL, 5'd4, 5'd3, 4'd8);
                24: u = mk(U_MUL, 5'd2, 5'd5, 4'd9);
                25: u = mk(U_ADD, 5'd8, 5'd9, 4'd10);
                26: u = mk(U_MUL, 5'd10, 5'd10, 4'd15);
                27: u = mk(U_MUL, 5'd8, 5'd9, 4'd10);
                28: u = mk(U_MUL, RB, 5'd15, 4'd11);
                29: u = mk(U_ADD, 5'd10, 5'd11, 4'd14);
                30: u = mk(U_MUL, 5'd0, 5'd0, 4'd8);
                31: u = mk(U_MUL, 5'd1, 5'd1, 4'd9);
                32: u = mk(U_MUL, 5'd8, 5'd9, 4'd13);
                33: u = mk(U_MUL, 5'd8, 5'd8, 4'd10);
                34: u = mk(U_MUL, 5'd9, 5'd9, 4'd11);
                35: u = mk(U_MUL, RC, 5'd11, 4'd11);
                36: u = mk(U_ADD, 5'd10, 5'd11, 4'd12);
                37: u = mk(U_MUL, 5'd14, 5'd13, 4'd8);
                38: u = mk(U_MUL, 5'd15, 5'd12, 4'd9);
                default: u = mk(U_CPY, 5'd0, 5'd0, 4'd0);
            endcase
        end
        return u;
    endfunction

    localparam logic [5:0] INIT_LAST = 6'd23;
    localparam logic [5:0] STEP_SH   = 6'd7;   // first op after shadow update
    localparam logic [5:0] STEP_LAD  = 6'd22;
    localparam logic [5:0] STEP_LAST = 6'd38;

    uop_t  uop;
    fe_t   opa, opb, sum, acc_sh;
    logic  is_init;
    logic [WORD_BITS-1:0] rd_word;

    always_comb
    begin
        is_init = (req_reg.opcode == OP_INIT);
        uop     = prog(is_init ? 2'd0 : 2'd1, pc_reg, req_reg.key_bit);
        opa     = (uop.a == RB) ? BASE_X
                : (uop.a == RC) ? CURVE_B : rf_reg[uop.a[3:0]];
        opb     = (uop.b == RB) ? BASE_X
                : (uop.b == RC) ? CURVE_B : rf_reg[uop.b[3:0]];
        sum     = opa ^ opb;
        acc_sh  = {acc_reg[FIELD_BITS-2:0], 1'b0}
                  ^ (acc_reg[FIELD_BITS-1] ? POLY_LOW : '0);
        // read word for a read request; targets 6 and 7 read zero
        rd_word = '0;
        if (opcode_t'(in_data.opcode) == OP_READ && in_data.target <= 3'd5)
            rd_word = in_data.word_index
                ? WORD_BITS'(rf_reg[{1'b0, in_data.target}][FIELD_BITS-1:WORD_BITS])
                : rf_reg[{1'b0, in_data.target}][WORD_BITS-1:0];
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_RESP);
    assign out_data  = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            started_reg <= 1'b0;
            fail_reg    <= '0;
            pc_reg      <= '0;
            bit_reg     <= '0;
            rsp_reg     <= '0;
            req_reg     <= '0;
            acc_reg     <= '0;
            ma_reg      <= '0;
            mb_reg      <= '0;
            for (int i = 0; i < 16; i++)
            begin
                rf_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg <= in_data;
                        rsp_reg.read_word   <= rd_word;
                        rsp_reg.mismatch    <= 1'b0;
                        rsp_reg.error_total <= fail_reg;
                        pc_reg <= '0;
                        case (opcode_t'(in_data.opcode))
                            OP_LOAD:
                            begin
                                if (in_data.target == 3'd0 || in_data.target == 3'd1)
                                begin
                                    if (in_data.word_index)
                                        rf_reg[{3'b011, in_data.target[0]}][FIELD_BITS-1:WORD_BITS]
                                            <= in_data.load_word[HI_BITS-1:0];
                                    else
                                        rf_reg[{3'b011, in_data.target[0]}][WORD_BITS-1:0]
                                            <= in_data.load_word;
                                end
                                state_reg <= S_RESP;
                            end
                            OP_READ:
                            begin
                                state_reg <= S_RESP;
                            end
                            OP_STEP:
                            begin
                                if (!started_reg)
                                begin
                                    rf_reg[4] <= in_data.key_bit ? rf_reg[2] : rf_reg[0];
                                    rf_reg[5] <= in_data.key_bit ? rf_reg[3] : rf_reg[1];
                                    pc_reg <= STEP_SH;
                                end
                                state_reg <= S_RUN;
                            end
                            default: state_reg <= S_RUN;
                        endcase
                    end
                end
                S_RUN:
                begin
                    case (uop.kind)
                        U_MUL:
                        begin
                            ma_reg  <= opa;
                            mb_reg  <= opb;
                            acc_reg <= '0;
                            bit_reg <= 7'(FIELD_BITS - 1);
                            state_reg <= S_MUL;
                        end
                        U_ADD, U_CPY:
                        begin
                            rf_reg[uop.d] <= (uop.kind == U_ADD) ? sum : opa;
                            if (is_init ? (pc_reg == INIT_LAST)
                                        : (pc_reg == STEP_LAD && !started_reg))
                            begin
                                if (is_init)
                                begin
                                    fail_reg <= '0;
                                    rsp_reg.error_total <= '0;
                                end
                                started_reg <= !is_init;
                                state_reg <= S_RESP;
                            end
                            else
                                pc_reg <= pc_reg + 6'd1;
                        end
                        default: state_reg <= S_IDLE;
                    endcase
                end
                S_MUL:
                begin
                    if (mb_reg[bit_reg])
                        acc_reg <= acc_sh ^ ma_reg;
                    else
                        acc_reg <= acc_sh;
                    if (bit_reg == '0)
                    begin
                        if (!is_init && pc_reg == STEP_LAST)
                        begin
                            // acc final = cr; compare with stored cl
                            if ((mb_reg[0] ? acc_sh ^ ma_reg : acc_sh) != rf_reg[8])
                            begin
                                rsp_reg.mismatch <= 1'b1;
                                if (fail_reg != 8'hFF)
                                begin
                                    fail_reg <= fail_reg + 8'd1;
                                    rsp_reg.error_total <= fail_reg + 8'd1;
                                end
                            end
                            state_reg <= S_RESP;
                        end
                        else
                        begin
                            rf_reg[uop.d] <= mb_reg[0] ? acc_sh ^ ma_reg : acc_sh;
                            pc_reg <= pc_reg + 6'd1;
                            state_reg <= S_RUN;
                        end
                    end
                    else
                        bit_reg <= bit_reg - 7'd1;
                end
                S_RESP:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
